// File: rtl/core/pfcd_pkg.sv
// shared constants, types and codes of the frame cache directory
package pfcd_pkg;

	localparam int SLOTS   = 64;
	localparam int SIDX_W  = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

	localparam logic [2:0] OP_LOOKUP  = 3'd0;
	localparam logic [2:0] OP_INSERT  = 3'd1;
	localparam logic [2:0] OP_RELEASE = 3'd2;
	localparam logic [2:0] OP_CLEAR   = 3'd3;
	localparam logic [2:0] OP_TICK    = 3'd4;

	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_MISS = 2'd1;
	localparam logic [1:0] STS_DUP  = 2'd2;
	localparam logic [1:0] STS_FULL = 2'd3;

	typedef struct packed {
		logic [15:0] file_id;
		logic [63:0] frame;
		logic [15:0] fmt_opt;
		logic [29:0] geo;
	} key_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] data_ref;
		logic [31:0] data_bytes;
		logic [15:0] ref_count;
		logic [31:0] last_use;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [2:0]  opcode;
		key_t        key;
		logic [31:0] buffer_ref;
		logic [31:0] buffer_bytes;
		logic [5:0]  slot_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  hit_slot;
		logic [31:0] hit_buffer_ref;
		logic [31:0] hit_buffer_bytes;
		logic        evicted;
		logic [31:0] evicted_buffer_ref;
		logic [31:0] hits_total;
		logic [31:0] misses_total;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic scan_step;
		logic rel_read;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       scan_last;
	} sts_t;

endpackage

// File: rtl/core/pfcd_ifs.sv
// request and response channel interfaces
interface pfcd_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [15:0]        file_id;
	logic signed [63:0] frame_number;
	logic [7:0]         image_format;
	logic [7:0]         format_option;
	logic [14:0]        image_width;
	logic [14:0]        image_height;
	logic [31:0]        buffer_ref;
	logic [31:0]        buffer_bytes;
	logic [5:0]         slot_handle;

	modport source (output valid, opcode, file_id, frame_number, image_format, format_option,
		image_width, image_height, buffer_ref, buffer_bytes, slot_handle, input ready);
	modport sink (input valid, opcode, file_id, frame_number, image_format, format_option,
		image_width, image_height, buffer_ref, buffer_bytes, slot_handle, output ready);
endinterface

interface pfcd_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  hit_slot;
	logic [31:0] hit_buffer_ref;
	logic [31:0] hit_buffer_bytes;
	logic        evicted;
	logic [31:0] evicted_buffer_ref;
	logic [31:0] hits_total;
	logic [31:0] misses_total;

	modport source (output valid, status, hit_slot, hit_buffer_ref, hit_buffer_bytes, evicted,
		evicted_buffer_ref, hits_total, misses_total, input ready);
	modport sink (input valid, status, hit_slot, hit_buffer_ref, hit_buffer_bytes, evicted,
		evicted_buffer_ref, hits_total, misses_total, output ready);
endinterface

// File: rtl/core/pfcd_ram.sv
// generic single write port ram with registered read
module pfcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/core/pfcd_ctrl.sv
// request sequencer: accept, scan (lookup and insert) or read one slot (release), update, respond
module pfcd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  pfcd_pkg::sts_t sts,
	output pfcd_pkg::cmd_t cmd
);
	import pfcd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DISP  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_RREAD = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_RESP  = 3'd6;

	logic [2:0] state_q, state_d;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = (state_q == ST_RESP);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				if (sts.op == OP_LOOKUP || sts.op == OP_INSERT) begin
					state_d = ST_SCAN;
				end else if (sts.op == OP_RELEASE) begin
					state_d = ST_RREAD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			// last slot's read data is compared here
			ST_DRAIN: state_d = ST_FIN;
			ST_RREAD: begin
				cmd.rel_read = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: rtl/core/pfcd_dp.sv
// directory datapath: entry ram, valid bits, scan trackers, counters, result register
module pfcd_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pfcd_pkg::LIMIT_W-1:0]    cfg_wdata,
	input  pfcd_pkg::req_t                  req,
	input  pfcd_pkg::cmd_t                  cmd,
	output pfcd_pkg::sts_t                  sts,
	output pfcd_pkg::rsp_t                  rsp
);
	import pfcd_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic [SLOTS-1:0]   valid_q;
	logic [CNT_W-1:0]   vcount_q;
	logic [31:0]        now_q, hits_q, miss_q;

	logic [2:0]        op_q;
	key_t              key_q;
	logic [31:0]       bref_q, bbytes_q;
	logic [5:0]        handle_q;
	logic              evict_en_q;

	logic [SIDX_W-1:0] idx_q;
	logic              cmp_vld_s1;
	logic [SIDX_W-1:0] cmp_idx_s1;

	logic              match_found_q, victim_found_q, free_found_q;
	logic [SIDX_W-1:0] match_idx_q, victim_idx_q, free_idx_q;
	entry_t            match_e_q;
	logic [31:0]       victim_lu_q, victim_ref_q;

	logic              ram_we, ram_re;
	logic [SIDX_W-1:0] ram_waddr, ram_raddr;
	entry_t            ram_wdata, rdata;

	logic [SIDX_W-1:0] hidx;
	logic              rel_ok, ev, dup, use_free, ins_ok;
	logic [SIDX_W-1:0] ins_slot;
	logic              hit_cmp, victim_cmp, free_cmp;
	rsp_t              rsp_d;
	logic [31:0]       hits_n, miss_n;

	pfcd_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	assign sts.op = op_q;
	assign sts.scan_last = (idx_q == SIDX_W'(SLOTS - 1));

	assign hidx = SIDX_W'(handle_q);
	assign ram_re = cmd.scan_step | cmd.rel_read;
	assign ram_raddr = cmd.rel_read ? hidx : idx_q;

	assign hit_cmp = cmp_vld_s1 && valid_q[cmp_idx_s1] && (rdata.key == key_q) && !match_found_q;
	assign victim_cmp = cmp_vld_s1 && evict_en_q && valid_q[cmp_idx_s1] &&
		(rdata.ref_count == 16'd0) && (!victim_found_q || rdata.last_use < victim_lu_q);
	assign free_cmp = cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_found_q;

	// keys are unique among valid entries, so a match on the victim is no duplicate
	assign ev = victim_found_q;
	assign dup = match_found_q && !(ev && match_idx_q == victim_idx_q);
	assign use_free = free_found_q && (!ev || free_idx_q < victim_idx_q);
	assign ins_slot = use_free ? free_idx_q : victim_idx_q;
	assign ins_ok = free_found_q || ev;
	assign rel_ok = (32'(handle_q) < SLOTS) && valid_q[hidx];

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = match_idx_q;
		ram_wdata = match_e_q;
		hits_n = hits_q;
		miss_n = miss_q;
		rsp_d = '0;
		case (op_q)
			OP_LOOKUP: begin
				if (match_found_q) begin
					ram_we = cmd.finish;
					if (match_e_q.ref_count != 16'hFFFF) begin
						ram_wdata.ref_count = match_e_q.ref_count + 16'd1;
					end
					ram_wdata.last_use = now_q;
					hits_n = hits_q + 32'd1;
					rsp_d.hit_slot = 6'(match_idx_q);
					rsp_d.hit_buffer_ref = match_e_q.data_ref;
					rsp_d.hit_buffer_bytes = match_e_q.data_bytes;
				end else begin
					miss_n = miss_q + 32'd1;
					rsp_d.status = STS_MISS;
				end
			end
			OP_INSERT: begin
				rsp_d.evicted = ev;
				rsp_d.evicted_buffer_ref = ev ? victim_ref_q : 32'd0;
				ram_waddr = ins_slot;
				ram_wdata.key = key_q;
				ram_wdata.data_ref = bref_q;
				ram_wdata.data_bytes = bbytes_q;
				ram_wdata.ref_count = 16'd0;
				ram_wdata.last_use = 32'd0;
				if (dup) begin
					rsp_d.status = STS_DUP;
					rsp_d.hit_slot = 6'(match_idx_q);
				end else if (ins_ok) begin
					ram_we = cmd.finish;
					rsp_d.hit_slot = 6'(ins_slot);
				end else begin
					rsp_d.status = STS_FULL;
				end
			end
			OP_RELEASE: begin
				ram_waddr = hidx;
				ram_wdata = rdata;
				if (rel_ok) begin
					ram_we = cmd.finish;
					if (rdata.ref_count != 16'd0) begin
						ram_wdata.ref_count = rdata.ref_count - 16'd1;
					end
					rsp_d.hit_slot = handle_q;
				end else begin
					rsp_d.status = STS_MISS;
				end
			end
			OP_CLEAR: begin
				hits_n = 32'd0;
				miss_n = 32'd0;
			end
			default: ;
		endcase
		rsp_d.hits_total = hits_n;
		rsp_d.misses_total = miss_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			valid_q <= '0;
			vcount_q <= '0;
			now_q <= '0;
			hits_q <= '0;
			miss_q <= '0;
			cmp_vld_s1 <= 1'b0;
			match_found_q <= 1'b0;
			victim_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_step;
			if (cmd.capture) begin
				match_found_q <= 1'b0;
				victim_found_q <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (hit_cmp) match_found_q <= 1'b1;
				if (victim_cmp) victim_found_q <= 1'b1;
				if (free_cmp) free_found_q <= 1'b1;
			end
			if (cfg_we) begin
				if (cfg_wdata < limit_q) begin
					valid_q <= '0;
					vcount_q <= '0;
					hits_q <= '0;
					miss_q <= '0;
				end
				if (cfg_wdata != '0) begin
					limit_q <= cfg_wdata;
				end
			end else if (cmd.finish) begin
				hits_q <= hits_n;
				miss_q <= miss_n;
				case (op_q)
					OP_INSERT: begin
						if (ev) valid_q[victim_idx_q] <= 1'b0;
						if (!dup && ins_ok) valid_q[ins_slot] <= 1'b1;
						vcount_q <= vcount_q - CNT_W'(ev) + CNT_W'(!dup && ins_ok);
					end
					OP_CLEAR: begin
						valid_q <= '0;
						vcount_q <= '0;
					end
					OP_TICK: now_q <= now_q + 32'd1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= req.opcode;
			key_q <= req.key;
			bref_q <= req.buffer_ref;
			bbytes_q <= req.buffer_bytes;
			handle_q <= req.slot_handle;
			evict_en_q <= (32'(vcount_q) >= 32'(limit_q));
			idx_q <= '0;
		end else if (cmd.scan_step) begin
			idx_q <= idx_q + SIDX_W'(1);
		end
		cmp_idx_s1 <= idx_q;
		if (hit_cmp) begin
			match_idx_q <= cmp_idx_s1;
			match_e_q <= rdata;
		end
		if (victim_cmp) begin
			victim_idx_q <= cmp_idx_s1;
			victim_lu_q <= rdata.last_use;
			victim_ref_q <= rdata.data_ref;
		end
		if (free_cmp) begin
			free_idx_q <= cmp_idx_s1;
		end
		if (cmd.finish) begin
			rsp <= rsp_d;
		end
	end
endmodule

// File: rtl/core/pinned_lru_frame_cache_directory.sv
// top level of the pinned lru frame cache directory
// One request at a time. A lookup or insert reads every one of the 64 entry ram slots in
// turn, one slot per cycle through the single read port; a release reads only its one
// slot, and a clear or tick reads none. The next request is taken the cycle after the
// response is accepted. An insert matches the key, picks the oldest unpinned victim (only
// once the entry limit is reached) and the lowest free slot in the same scan.
// Writes to entry_limit are expected only while no request is in flight.
module pinned_lru_frame_cache_directory (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pfcd_pkg::LIMIT_W-1:0] cfg_wdata,
	pfcd_req_if.sink                     req,
	pfcd_rsp_if.source                   rsp
);
	import pfcd_pkg::*;

	req_t rq;
	rsp_t rs;
	cmd_t cmd;
	sts_t sts;

	assign rq.opcode = req.opcode;
	assign rq.key.file_id = req.file_id;
	assign rq.key.frame = req.frame_number;
	assign rq.key.fmt_opt = {req.image_format, req.format_option};
	assign rq.key.geo = {req.image_width, req.image_height};
	assign rq.buffer_ref = req.buffer_ref;
	assign rq.buffer_bytes = req.buffer_bytes;
	assign rq.slot_handle = req.slot_handle;

	pfcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pfcd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (rq),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rs)
	);

	assign rsp.status = rs.status;
	assign rsp.hit_slot = rs.hit_slot;
	assign rsp.hit_buffer_ref = rs.hit_buffer_ref;
	assign rsp.hit_buffer_bytes = rs.hit_buffer_bytes;
	assign rsp.evicted = rs.evicted;
	assign rsp.evicted_buffer_ref = rs.evicted_buffer_ref;
	assign rsp.hits_total = rs.hits_total;
	assign rsp.misses_total = rs.misses_total;
endmodule

// File: test/tb_top.sv
// testbench of the pinned lru frame cache directory: directed requests, then random phases
`timescale 1ns / 100ps

module tb_top;
	import pfcd_pkg::*;

	localparam int MAX_CYCLES = 4000000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	pfcd_req_if req ();
	pfcd_rsp_if rsp ();

	pinned_lru_frame_cache_directory dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req.sink), .rsp(rsp.source)
	);

	always #5 clk = ~clk;

	// directory shadow
	logic        dir_valid [SLOTS];
	key_t        dir_key [SLOTS];
	logic [15:0] dir_pins [SLOTS];
	logic [31:0] dir_stamp [SLOTS];
	logic [31:0] dir_ref [SLOTS];
	logic [31:0] dir_bytes [SLOTS];
	logic [31:0] clock_now, hit_cnt, miss_cnt;
	logic [LIMIT_W-1:0] limit_now;

	rsp_t pending_rsp [$];
	int mismatches = 0;
	int accepted = 0;
	int responses = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int n_hit = 0, n_dup = 0, n_full = 0, n_evict = 0;

	function automatic void dir_clear();
		for (int i = 0; i < SLOTS; i++) dir_valid[i] = 1'b0;
		hit_cnt = '0;
		miss_cnt = '0;
	endfunction

	function automatic int dir_find(key_t k);
		for (int i = 0; i < SLOTS; i++)
			if (dir_valid[i] && dir_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void dir_set_limit(logic [LIMIT_W-1:0] v);
		if (v < limit_now) dir_clear();
		if (v != 0) limit_now = v;
	endfunction

	function automatic rsp_t dir_apply(req_t r);
		rsp_t o;
		int s, victim, free_slot, used;
		o = '0;
		case (r.opcode)
			OP_LOOKUP: begin
				s = dir_find(r.key);
				if (s >= 0) begin
					if (dir_pins[s] != 16'hffff) dir_pins[s]++;
					dir_stamp[s] = clock_now;
					hit_cnt++;
					o.hit_slot = s[5:0];
					o.hit_buffer_ref = dir_ref[s];
					o.hit_buffer_bytes = dir_bytes[s];
				end else begin
					miss_cnt++;
					o.status = STS_MISS;
				end
			end
			OP_INSERT: begin
				used = 0;
				victim = -1;
				free_slot = -1;
				for (int i = 0; i < SLOTS; i++) if (dir_valid[i]) used++;
				if (used >= limit_now) begin
					for (int i = 0; i < SLOTS; i++)
						if (dir_valid[i] && dir_pins[i] == 0 &&
							(victim < 0 || dir_stamp[i] < dir_stamp[victim]))
							victim = i;
					if (victim >= 0) begin
						dir_valid[victim] = 1'b0;
						o.evicted = 1'b1;
						o.evicted_buffer_ref = dir_ref[victim];
					end
				end
				s = dir_find(r.key);
				if (s >= 0) begin
					o.status = STS_DUP;
					o.hit_slot = s[5:0];
				end else begin
					for (int i = SLOTS - 1; i >= 0; i--) if (!dir_valid[i]) free_slot = i;
					if (free_slot < 0) begin
						o.status = STS_FULL;
					end else begin
						dir_valid[free_slot] = 1'b1;
						dir_key[free_slot] = r.key;
						dir_pins[free_slot] = '0;
						dir_stamp[free_slot] = '0;
						dir_ref[free_slot] = r.buffer_ref;
						dir_bytes[free_slot] = r.buffer_bytes;
						o.hit_slot = free_slot[5:0];
					end
				end
			end
			OP_RELEASE: begin
				if (dir_valid[r.slot_handle]) begin
					if (dir_pins[r.slot_handle] != 0) dir_pins[r.slot_handle]--;
					o.hit_slot = r.slot_handle;
				end else begin
					o.status = STS_MISS;
				end
			end
			OP_CLEAR: dir_clear();
			OP_TICK: clock_now++;
			default: ;
		endcase
		o.hits_total = hit_cnt;
		o.misses_total = miss_cnt;
		return o;
	endfunction

	// sender: valid stays high across back-to-back requests
	task automatic send_req(req_t r, bit typed, rsp_t typed_rsp);
		rsp_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= r.opcode;
		req.file_id <= r.key.file_id;
		req.frame_number <= r.key.frame;
		req.image_format <= r.key.fmt_opt[15:8];
		req.format_option <= r.key.fmt_opt[7:0];
		req.image_width <= r.key.geo[29:15];
		req.image_height <= r.key.geo[14:0];
		req.buffer_ref <= r.buffer_ref;
		req.buffer_bytes <= r.buffer_bytes;
		req.slot_handle <= r.slot_handle;
		do @(posedge clk); while (!req.ready);
		p = dir_apply(r);
		pending_rsp.push_back(typed ? typed_rsp : p);
		accepted++;
	endtask

	task automatic send(req_t r);
		send_req(r, 1'b0, '0);
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		dir_set_limit(v);
	endtask

	function automatic key_t rand_key();
		key_t k;
		k.file_id = 16'($urandom());
		k.frame = {$urandom(), $urandom()};
		k.fmt_opt = 16'($urandom());
		k.geo = 30'($urandom());
		return k;
	endfunction

	function automatic req_t mk(logic [2:0] op, key_t k, logic [31:0] bref, logic [31:0] bb,
		int h);
		req_t r;
		r.opcode = op;
		r.key = k;
		r.buffer_ref = bref;
		r.buffer_bytes = bb;
		r.slot_handle = 6'(h);
		return r;
	endfunction

	// response checker
	always @(posedge clk) begin
		rsp_t got, want;
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
		if (arst_n && rsp.valid && rsp.ready) begin
			got = '{rsp.status, rsp.hit_slot, rsp.hit_buffer_ref, rsp.hit_buffer_bytes,
				rsp.evicted, rsp.evicted_buffer_ref, rsp.hits_total, rsp.misses_total};
			responses++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", got);
			end else begin
				want = pending_rsp.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response %0d mismatch\n  exp %p\n  got %p",
							responses, want, got);
				end
				if (got.status == STS_OK && got.hit_buffer_ref != 0) n_hit++;
				if (got.status == STS_DUP) n_dup++;
				if (got.status == STS_FULL) n_full++;
				if (got.evicted) n_evict++;
			end
		end
	end

	initial begin
		key_t kmax, kzero, pool [$], k;
		req_t rows [$];
		bit row_typed [$];
		rsp_t row_rsp [$];
		logic [LIMIT_W-1:0] phase_limit [8] = '{1, 4, 127, 0, 64, 2, 16, 32};
		int r, s, pool_n, hold;

		req.valid = 1'b0;
		req.opcode = '0;
		req.file_id = '0;
		req.frame_number = '0;
		req.image_format = '0;
		req.format_option = '0;
		req.image_width = '0;
		req.image_height = '0;
		req.buffer_ref = '0;
		req.buffer_bytes = '0;
		req.slot_handle = '0;
		rsp.ready = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			dir_pins[i] = '0;
			dir_stamp[i] = '0;
			dir_ref[i] = '0;
			dir_bytes[i] = '0;
			dir_key[i] = '0;
		end
		clock_now = '0;
		limit_now = LIMIT_RESET;
		dir_clear();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests, some with hand-written expectations
		kmax = '1;
		kzero = '0;
		rows.push_back(mk(OP_LOOKUP, kmax, 0, 0, 0)); row_typed.push_back(1);
		row_rsp.push_back('{STS_MISS, 0, 0, 0, 0, 0, 0, 1});
		rows.push_back(mk(OP_INSERT, kmax, '1, '1, 0)); row_typed.push_back(1);
		row_rsp.push_back('{STS_OK, 0, 0, 0, 0, 0, 0, 1});
		rows.push_back(mk(OP_LOOKUP, kmax, 0, 0, 0)); row_typed.push_back(0);
		row_rsp.push_back('0);
		rows.push_back(mk(OP_INSERT, kmax, 7, 9, 0)); row_typed.push_back(1);
		row_rsp.push_back('{STS_DUP, 0, 0, 0, 0, 0, 1, 1});
		rows.push_back(mk(OP_RELEASE, kzero, 0, 0, 63)); row_typed.push_back(1);
		row_rsp.push_back('{STS_MISS, 0, 0, 0, 0, 0, 1, 1});
		// second release hits a count already at zero
		rows.push_back(mk(OP_RELEASE, kzero, 0, 0, 0)); row_typed.push_back(0);
		row_rsp.push_back('0);
		rows.push_back(mk(OP_RELEASE, kzero, 0, 0, 0)); row_typed.push_back(0);
		row_rsp.push_back('0);
		rows.push_back(mk(OP_INSERT, kzero, 0, 0, 0)); row_typed.push_back(0);
		row_rsp.push_back('0);
		rows.push_back(mk(OP_TICK, kzero, 0, 0, 0)); row_typed.push_back(0);
		row_rsp.push_back('0);
		rows.push_back(mk(OP_LOOKUP, kzero, 0, 0, 0)); row_typed.push_back(0);
		row_rsp.push_back('0);
		for (int op = 5; op < 8; op++) begin
			rows.push_back(mk(3'(op), kmax, '1, '1, 63)); row_typed.push_back(1);
			row_rsp.push_back('{STS_OK, 0, 0, 0, 0, 0, 2, 1});
		end
		rows.push_back(mk(OP_INSERT, rand_key(), 1, 2, 0)); row_typed.push_back(0);
		row_rsp.push_back('0);
		rows.push_back(mk(OP_CLEAR, kmax, 0, 0, 0)); row_typed.push_back(1);
		row_rsp.push_back('{STS_OK, 0, 0, 0, 0, 0, 0, 0});
		rows.push_back(mk(OP_LOOKUP, kmax, 0, 0, 0)); row_typed.push_back(1);
		row_rsp.push_back('{STS_MISS, 0, 0, 0, 0, 0, 0, 1});
		foreach (rows[i]) send_req(rows[i], row_typed[i], row_rsp[i]);

		for (int ph = 0; ph < 8; ph++) begin
			write_limit(phase_limit[ph]);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 65; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 65; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			if (phase_limit[ph] == 64) begin
				// fill every slot, pin all, then one more insert finds no room
				for (int i = 0; i < SLOTS; i++) begin
					k = rand_key();
					k.file_id = 16'(i);
					send(mk(OP_INSERT, k, $urandom(), $urandom(), 0));
					send(mk(OP_LOOKUP, k, 0, 0, 0));
					if (i % 8 == 0) send(mk(OP_TICK, k, 0, 0, 0));
				end
				send(mk(OP_INSERT, rand_key(), $urandom(), $urandom(), 0));
				for (int i = 0; i < SLOTS; i += 3)
					send(mk(OP_RELEASE, kzero, 0, 0, i));
				for (int i = 0; i < 8; i++)
					send(mk(OP_INSERT, rand_key(), $urandom(), $urandom(), 0));
				continue;
			end
			pool.delete();
			pool_n = (limit_now > 20) ? 40 : 2 * limit_now + 3;
			for (int i = 0; i < pool_n; i++) pool.push_back(rand_key());
			for (int n = 0; n < 175; n++) begin
				k = pool[$urandom_range(pool_n - 1)];
				r = $urandom_range(99);
				if (r < 25) begin
					// insert, hit it, sometimes let it go again
					send(mk(OP_INSERT, k, $urandom(), $urandom(), 0));
					send(mk(OP_LOOKUP, k, 0, 0, 0));
					s = dir_find(k);
					hold = $urandom_range(3);
					if (s >= 0 && hold != 0) send(mk(OP_RELEASE, k, 0, 0, s));
				end else if (r < 50) send(mk(OP_LOOKUP, k, 0, 0, 0));
				else if (r < 65) send(mk(OP_INSERT, k, $urandom(), $urandom(), 0));
				else if (r < 80) send(mk(OP_RELEASE, k, 0, 0,
					($urandom_range(3) != 0) ? $urandom_range(7) : $urandom_range(63)));
				else if (r < 94) send(mk(OP_TICK, k, 0, 0, 0));
				else if (r < 96) send(mk(OP_CLEAR, k, 0, 0, 0));
				else if (r < 98) send(mk(3'($urandom_range(7, 5)), rand_key(), $urandom(),
					$urandom(), $urandom()));
				else send(mk(OP_LOOKUP, rand_key(), 0, 0, 0));
			end
		end

		req.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests over 8 limit settings and 4 handshake idling patterns", accepted);
		$display("%0d hits, %0d duplicates, %0d no-room, %0d evictions; %0d mismatches",
			n_hit, n_dup, n_full, n_evict, mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
